// ===== hdl/refcounted_lru_cache_directory_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the cache directory
// ---------------------------------------------------------------------------
`ifndef REFCOUNTED_LRU_CACHE_DIRECTORY_DEFINES_SVH
`define REFCOUNTED_LRU_CACHE_DIRECTORY_DEFINES_SVH
`ifndef SYNTHESIS
`define RLCD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RLCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RLCD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define RLCD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/rlcd_pkg.sv =====
// ---------------------------------------------------------------------------
// rlcd_pkg
// Shared constants and helpers of the cache directory.
// ---------------------------------------------------------------------------
package rlcd_pkg;

  localparam logic [3:0] ST_HIT        = 4'd0;
  localparam logic [3:0] ST_INSERTED   = 4'd1;
  localparam logic [3:0] ST_NOT_AVAIL  = 4'd2;
  localparam logic [3:0] ST_NO_SLOT    = 4'd3;
  localparam logic [3:0] ST_REL_HELD   = 4'd4;
  localparam logic [3:0] ST_REL_IDLE   = 4'd5;
  localparam logic [3:0] ST_DOUBLE_REL = 4'd6;
  localparam logic [3:0] ST_UNKNOWN    = 4'd7;
  localparam logic [3:0] ST_SATURATED  = 4'd8;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [23:0] BUDGET_RESET = 24'd2000000;

  // uppercase a-z, zero everything from the first zero byte on
  function automatic logic [63:0] normalize_key(input logic [63:0] k);
    logic [63:0] r;
    logic        ended;
    logic [7:0]  b;
    r     = '0;
    ended = 1'b0;
    for (int i = 0; i < 8; i++) begin
      b = k[8*i +: 8];
      if (ended || b == 8'd0) begin
        ended = 1'b1;
        b     = 8'd0;
      end
      if (b >= 8'h61 && b <= 8'h7A) begin
        b = b - 8'h20;
      end
      r[8*i +: 8] = b;
    end
    return r;
  endfunction

endpackage

// ===== hdl/rlcd_ram.sv =====
// ---------------------------------------------------------------------------
// rlcd_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module rlcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/refcounted_lru_cache_directory.sv =====
// ---------------------------------------------------------------------------
// refcounted_lru_cache_directory
// Reference-counted LRU cache directory with a free-byte budget.
// ---------------------------------------------------------------------------
// Sequence: a release reads and updates the refcount, an unknown handle goes
//   straight to the output; an acquire scans the keys up to a match or the last
//   slot, unlinks an idle hit from the LRU list, and on an available miss evicts
//   LRU entries for the budget and one more if the table is full, then inserts.
// Throughput: one item at a time; the serial key scan through the key RAM
//   (one read port, one slot per cycle) sets the rate.
// Reset (rst_n, synchronous): table empty, LRU list empty, budget register
//   and free-byte counter at 2000000. RAM contents are not cleared.
`include "refcounted_lru_cache_directory_defines.svh"

module refcounted_lru_cache_directory
  import rlcd_pkg::*;
#(
  parameter int ENTRIES   = 32,
  parameter int SIZE_BITS = 24,
  parameter int REF_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [63:0] in_name_key,
  input  logic [23:0] in_item_size,
  input  logic        in_item_available,
  input  logic [4:0]  in_slot_handle,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_status,
  output logic [4:0]  out_slot,
  output logic [15:0] out_ref_count,
  output logic [5:0]  out_evicted_count,
  output logic signed [29:0] out_free_bytes,
  output logic        out_over_budget,
  output logic [5:0]  out_entry_count,
  // budget register
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data
);

  localparam int IW   = $clog2(ENTRIES);
  localparam int CW   = $clog2(ENTRIES + 1);
  // budget counter: budget minus all charged bytes, with headroom
  localparam int BL_W = ((SIZE_BITS > 24) ? SIZE_BITS : 24) + CW + 2;
  localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;   // serial key compare
  localparam logic [3:0] S_MISS = 4'd2;
  localparam logic [3:0] S_HREQ = 4'd3;   // refcount read on hit
  localparam logic [3:0] S_HIT  = 4'd4;
  localparam logic [3:0] S_RREQ = 4'd5;   // refcount read on release
  localparam logic [3:0] S_REL  = 4'd6;
  localparam logic [3:0] S_EVAL = 4'd7;   // budget eviction loop
  localparam logic [3:0] S_FULL = 4'd8;   // table-full eviction
  localparam logic [3:0] S_INS  = 4'd9;
  localparam logic [3:0] S_RM0  = 4'd10;  // LRU unlink: read links
  localparam logic [3:0] S_RM1  = 4'd11;  // LRU unlink: patch links
  localparam logic [3:0] S_OUT  = 4'd12;

  logic [3:0] state_r, state_nxt, ret_r, ret_nxt;

  // latched item
  logic [63:0]          key_r, key_nxt;
  logic [SIZE_BITS-1:0] size_r, size_nxt;
  logic                 avail_r, avail_nxt;

  // directory state
  logic [ENTRIES-1:0]   valid_r, valid_nxt;
  logic [IW-1:0]        head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0]        len_r, len_nxt, live_r, live_nxt;
  logic signed [BL_W-1:0] budget_r, budget_nxt;
  logic [23:0]          bbytes_r;

  // scan and sequencer work registers
  logic [IW-1:0] idx_r, idx_nxt, pidx_r, pidx_nxt;
  logic          pend_r, pend_nxt, issued_r, issued_nxt;
  logic [IW-1:0] free_r, free_nxt;
  logic          ffound_r, ffound_nxt;
  logic [IW-1:0] cur_r, cur_nxt, rm_r, rm_nxt;
  logic          rmev_r, rmev_nxt;

  // result under construction
  logic [3:0]          res_status_r, res_status_nxt;
  logic [IW-1:0]       res_slot_r, res_slot_nxt;
  logic [REF_BITS-1:0] res_refs_r, res_refs_nxt;
  logic [CW-1:0]       ev_r, ev_nxt;
  logic                over_r, over_nxt;
  logic [4:0]          hslot_r, hslot_nxt;   // raw handle for releases
  logic                use_h_r, use_h_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [3:0]  o_status_r, o_status_nxt;
  logic [4:0]  o_slot_r, o_slot_nxt;
  logic [15:0] o_refs_r, o_refs_nxt;
  logic [5:0]  o_ev_r, o_ev_nxt;
  logic signed [29:0] o_fb_r, o_fb_nxt;
  logic        o_over_r, o_over_nxt;
  logic [5:0]  o_cnt_r, o_cnt_nxt;

  // RAM ports
  logic                 key_we;
  logic [63:0]          key_q;
  logic                 refs_we;
  logic [IW-1:0]        refs_wa;
  logic [REF_BITS-1:0]  refs_wd, refs_q;
  logic                 bytes_we;
  logic [SIZE_BITS-1:0] bytes_q;
  logic                 nx_we, pv_we;
  logic [IW-1:0]        nx_wa, nx_wd, nx_q, pv_wa, pv_wd, pv_q;

  rlcd_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(free_r), .wdata(key_r),
    .raddr(idx_r), .rdata(key_q));

  rlcd_ram #(.WIDTH(REF_BITS), .DEPTH(ENTRIES)) u_refs_ram (
    .clk(clk), .we(refs_we), .waddr(refs_wa), .wdata(refs_wd),
    .raddr(cur_r), .rdata(refs_q));

  rlcd_ram #(.WIDTH(SIZE_BITS), .DEPTH(ENTRIES)) u_bytes_ram (
    .clk(clk), .we(bytes_we), .waddr(free_r), .wdata(size_r),
    .raddr(rm_r), .rdata(bytes_q));

  rlcd_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_next_ram (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
    .raddr(rm_r), .rdata(nx_q));

  rlcd_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_prev_ram (
    .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd),
    .raddr(rm_r), .rdata(pv_q));

  logic [IW-1:0]        in_hidx;
  logic                 in_h_bad;
  logic signed [BL_W-1:0] size_s;
  logic signed [63:0]   fb_wide;
  logic [REF_BITS-1:0]  refs_dec;

  assign in_hidx  = IW'(in_slot_handle);
  assign in_h_bad = (32'(in_slot_handle) >= ENTRIES) || !valid_r[in_hidx];
  assign size_s   = $signed(BL_W'(size_r));
  assign refs_dec = refs_q - 1'b1;
  assign in_ready = (state_r == S_IDLE);

  // clamp the budget counter to the 30-bit result field
  always_comb begin
    fb_wide = 64'(budget_r);
    if (fb_wide < -64'sd536870912) begin
      fb_wide = -64'sd536870912;
    end else if (fb_wide > 64'sd536870911) begin
      fb_wide = 64'sd536870911;
    end
  end

  always_comb begin
    state_nxt = state_r;    ret_nxt = ret_r;
    key_nxt = key_r;        size_nxt = size_r;      avail_nxt = avail_r;
    valid_nxt = valid_r;    head_nxt = head_r;      tail_nxt = tail_r;
    len_nxt = len_r;        live_nxt = live_r;      budget_nxt = budget_r;
    idx_nxt = idx_r;        pidx_nxt = pidx_r;      pend_nxt = pend_r;
    issued_nxt = issued_r;  free_nxt = free_r;      ffound_nxt = ffound_r;
    cur_nxt = cur_r;        rm_nxt = rm_r;          rmev_nxt = rmev_r;
    res_status_nxt = res_status_r;  res_slot_nxt = res_slot_r;
    res_refs_nxt = res_refs_r;      ev_nxt = ev_r;  over_nxt = over_r;
    hslot_nxt = hslot_r;    use_h_nxt = use_h_r;
    out_valid_nxt = out_valid_r && !out_ready;
    o_status_nxt = o_status_r;  o_slot_nxt = o_slot_r;  o_refs_nxt = o_refs_r;
    o_ev_nxt = o_ev_r;          o_fb_nxt = o_fb_r;      o_over_nxt = o_over_r;
    o_cnt_nxt = o_cnt_r;
    key_we = 1'b0;  bytes_we = 1'b0;
    refs_we = 1'b0; refs_wa = cur_r; refs_wd = refs_q;
    nx_we = 1'b0;   nx_wa = tail_r;  nx_wd = cur_r;
    pv_we = 1'b0;   pv_wa = cur_r;   pv_wd = tail_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt        = normalize_key(in_name_key);
          size_nxt       = SIZE_BITS'(in_item_size);
          avail_nxt      = in_item_available;
          res_status_nxt = ST_HIT;
          res_slot_nxt   = '0;
          res_refs_nxt   = '0;
          ev_nxt         = '0;
          over_nxt       = 1'b0;
          use_h_nxt      = 1'b0;
          hslot_nxt      = in_slot_handle;
          idx_nxt        = '0;
          pend_nxt       = 1'b0;
          issued_nxt     = 1'b0;
          ffound_nxt     = 1'b0;
          free_nxt       = '0;
          if (in_operation == OP_RELEASE) begin
            use_h_nxt = 1'b1;
            cur_nxt   = in_hidx;
            if (in_h_bad) begin
              res_status_nxt = ST_UNKNOWN;
              state_nxt      = S_OUT;
            end else begin
              state_nxt = S_RREQ;
            end
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // issue one key read per cycle, compare the previous one
        pend_nxt = 1'b0;
        if (!issued_r) begin
          pend_nxt = 1'b1;
          pidx_nxt = idx_r;
          if (idx_r == LAST_IDX) begin
            issued_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        if (pend_r) begin
          if (!valid_r[pidx_r] && !ffound_r) begin
            ffound_nxt = 1'b1;
            free_nxt   = pidx_r;
          end
          if (valid_r[pidx_r] && key_q == key_r) begin
            cur_nxt   = pidx_r;
            state_nxt = S_HREQ;
          end else if (pidx_r == LAST_IDX) begin
            state_nxt = S_MISS;
          end
        end
      end

      S_HREQ: state_nxt = S_HIT;

      S_HIT: begin
        res_slot_nxt = cur_r;
        if (refs_q == REF_MAX) begin
          res_status_nxt = ST_SATURATED;
          res_refs_nxt   = refs_q;
          state_nxt      = S_OUT;
        end else begin
          refs_we        = 1'b1;
          refs_wd        = refs_q + 1'b1;
          res_status_nxt = ST_HIT;
          res_refs_nxt   = refs_q + 1'b1;
          if (refs_q == '0) begin
            rm_nxt    = cur_r;
            rmev_nxt  = 1'b0;
            ret_nxt   = S_OUT;
            state_nxt = S_RM0;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end

      S_RREQ: state_nxt = S_REL;

      S_REL: begin
        state_nxt = S_OUT;
        if (refs_q == '0) begin
          res_status_nxt = ST_DOUBLE_REL;
        end else begin
          refs_we      = 1'b1;
          refs_wd      = refs_dec;
          res_refs_nxt = refs_dec;
          if (refs_dec == '0) begin
            // push onto the LRU tail
            res_status_nxt = ST_REL_IDLE;
            if (len_r == '0) begin
              head_nxt = cur_r;
            end else begin
              nx_we = 1'b1;
              pv_we = 1'b1;
            end
            tail_nxt = cur_r;
            len_nxt  = len_r + 1'b1;
          end else begin
            res_status_nxt = ST_REL_HELD;
          end
        end
      end

      S_MISS: begin
        if (!avail_r) begin
          res_status_nxt = ST_NOT_AVAIL;
          state_nxt      = S_OUT;
        end else if (32'(live_r) >= ENTRIES && len_r == '0) begin
          res_status_nxt = ST_NO_SLOT;
          state_nxt      = S_OUT;
        end else begin
          state_nxt = S_EVAL;
        end
      end

      S_EVAL: begin
        if (budget_r < size_s) begin
          if (len_r == '0) begin
            over_nxt  = 1'b1;
            state_nxt = S_FULL;
          end else begin
            rm_nxt    = head_r;
            rmev_nxt  = 1'b1;
            ret_nxt   = S_EVAL;
            state_nxt = S_RM0;
          end
        end else begin
          state_nxt = S_FULL;
        end
      end

      S_FULL: begin
        if (32'(live_r) >= ENTRIES && len_r != '0) begin
          rm_nxt    = head_r;
          rmev_nxt  = 1'b1;
          ret_nxt   = S_INS;
          state_nxt = S_RM0;
        end else begin
          state_nxt = S_INS;
        end
      end

      S_INS: begin
        state_nxt = S_OUT;
        if (!ffound_r) begin
          res_status_nxt = ST_NO_SLOT;
        end else begin
          key_we             = 1'b1;
          bytes_we           = 1'b1;
          refs_we            = 1'b1;
          refs_wa            = free_r;
          refs_wd            = REF_BITS'(1);
          valid_nxt[free_r]  = 1'b1;
          live_nxt           = live_r + 1'b1;
          budget_nxt         = budget_r - size_s;
          res_status_nxt     = ST_INSERTED;
          res_slot_nxt       = free_r;
          res_refs_nxt       = REF_BITS'(1);
        end
      end

      S_RM0: state_nxt = S_RM1;

      S_RM1: begin
        // unlink rm_r; links are patched only for a middle entry
        if (len_r <= CW'(1)) begin
          len_nxt = '0;
        end else begin
          if (rm_r == head_r) begin
            head_nxt = nx_q;
          end else if (rm_r == tail_r) begin
            tail_nxt = pv_q;
          end else begin
            nx_we = 1'b1;
            nx_wa = pv_q;
            nx_wd = nx_q;
            pv_we = 1'b1;
            pv_wa = nx_q;
            pv_wd = pv_q;
          end
          len_nxt = len_r - 1'b1;
        end
        if (rmev_r) begin
          valid_nxt[rm_r] = 1'b0;
          live_nxt        = live_r - 1'b1;
          budget_nxt      = budget_r + $signed(BL_W'(bytes_q));
          ev_nxt          = ev_r + 1'b1;
          if (!ffound_r || rm_r < free_r) begin
            ffound_nxt = 1'b1;
            free_nxt   = rm_r;
          end
        end
        state_nxt = ret_r;
      end

      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = res_status_r;
          o_slot_nxt    = use_h_r ? hslot_r : 5'(res_slot_r);
          o_refs_nxt    = 16'(res_refs_r);
          o_ev_nxt      = 6'(ev_r);
          o_fb_nxt      = 30'(fb_wide);
          o_over_nxt    = over_r;
          o_cnt_nxt     = 6'(live_r);
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // user writes budget only while idle (not enforced); charged bytes kept
    if (cfg_wr_en) begin
      budget_nxt = budget_r + BL_W'($signed({2'b00, cfg_wr_data})
                                  - $signed({2'b00, bbytes_r}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      valid_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      len_r       <= '0;
      live_r      <= '0;
      budget_r    <= BL_W'(BUDGET_RESET);
      bbytes_r    <= BUDGET_RESET;
      pend_r      <= 1'b0;
      issued_r    <= 1'b0;
      ffound_r    <= 1'b0;
      rmev_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      valid_r     <= valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      len_r       <= len_nxt;
      live_r      <= live_nxt;
      budget_r    <= budget_nxt;
      if (cfg_wr_en) begin
        bbytes_r <= cfg_wr_data;
      end
      pend_r      <= pend_nxt;
      issued_r    <= issued_nxt;
      ffound_r    <= ffound_nxt;
      rmev_r      <= rmev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    size_r       <= size_nxt;
    avail_r      <= avail_nxt;
    idx_r        <= idx_nxt;
    pidx_r       <= pidx_nxt;
    free_r       <= free_nxt;
    cur_r        <= cur_nxt;
    rm_r         <= rm_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_refs_r   <= res_refs_nxt;
    ev_r         <= ev_nxt;
    over_r       <= over_nxt;
    hslot_r      <= hslot_nxt;
    use_h_r      <= use_h_nxt;
    o_status_r   <= o_status_nxt;
    o_slot_r     <= o_slot_nxt;
    o_refs_r     <= o_refs_nxt;
    o_ev_r       <= o_ev_nxt;
    o_fb_r       <= o_fb_nxt;
    o_over_r     <= o_over_nxt;
    o_cnt_r      <= o_cnt_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = o_status_r;
  assign out_slot          = o_slot_r;
  assign out_ref_count     = o_refs_r;
  assign out_evicted_count = o_ev_r;
  assign out_free_bytes    = o_fb_r;
  assign out_over_budget   = o_over_r;
  assign out_entry_count   = o_cnt_r;

  // idle entries are a subset of live entries
  `RLCD_ASSERT_SAME(a_len_le_live, clk, rst_n, 1'b1, len_r <= live_r)
  `RLCD_ASSERT_SAME(a_live_bound, clk, rst_n, 1'b1, 32'(live_r) <= ENTRIES)
  // an insert never lands on a live slot
  `RLCD_ASSERT_SAME(a_ins_free, clk, rst_n, state_r == S_INS && ffound_r,
                    !valid_r[free_r])
  // one item at a time
  `RLCD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule
